// File: src/hex8_shape_function_eval_macros.svh
// Assertion macros shared by the hex8 shape function evaluator.
`ifndef HEX8_SHAPE_FUNCTION_EVAL_MACROS_SVH
`define HEX8_SHAPE_FUNCTION_EVAL_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define HEX8SFE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define HEX8SFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/hex8sfe_pkg.sv
// Package: node ordering and output limits of the hex8 shape function evaluator.
package hex8sfe_pkg;

    localparam int unsigned NODE_COUNT = 8;
    localparam logic [2:0] LAST_NODE = 3'd7;
    localparam logic [14:0] SHAPE_MAX = 15'd32767;
    localparam logic [13:0] DERIV_MAG_MAX = 14'd16383;

    // Corner signs per node: bit0 xi positive, bit1 eta positive, bit2 zeta positive.
    function automatic logic [2:0] corner_bits(input logic [2:0] node);
        logic [2:0] bits;
        case (node)
            3'd0: bits = 3'b000;
            3'd1: bits = 3'b001;
            3'd2: bits = 3'b011;
            3'd3: bits = 3'b010;
            3'd4: bits = 3'b100;
            3'd5: bits = 3'b101;
            3'd6: bits = 3'b111;
            3'd7: bits = 3'b110;
            default: bits = 3'b000;
        endcase
        return bits;
    endfunction

endpackage

// File: src/hex8sfe_if.sv
// Channel interfaces: local point items in, node result items out.
interface hex8sfe_point_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] coord_xi;
    logic signed [15:0] coord_eta;
    logic signed [15:0] coord_zeta;

    modport source (output valid, coord_xi, coord_eta, coord_zeta, input ready);
    modport sink (input valid, coord_xi, coord_eta, coord_zeta, output ready);
endinterface

interface hex8sfe_node_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  node_index;
    logic        [14:0] shape_value;
    logic signed [14:0] deriv_xi;
    logic signed [14:0] deriv_eta;
    logic signed [14:0] deriv_zeta;
    logic               last_node;

    modport source (output valid, node_index, shape_value, deriv_xi, deriv_eta,
                    deriv_zeta, last_node, input ready);
    modport sink (input valid, node_index, shape_value, deriv_xi, deriv_eta,
                  deriv_zeta, last_node, output ready);
endinterface

// File: src/hex8_shape_function_eval.sv
// Trilinear hex8 shape functions and their derivatives, one node per cycle unless the output stalls.
// Usage:
//   point (sink): one local point (coord_xi, coord_eta, coord_zeta), signed with
//   FRAC_BITS fraction bits; each coordinate is clamped to [-1, 1].
//   node (source): eight result items per point, nodes 0..7 in corner order,
//   each with shape_value and the three partial derivatives; last_node marks
//   node 7. Items move on valid && ready.
// Timing:
//   The first node of a point passes from the point hold register through
//   stage 1 and stage 2 into the output register; the remaining nodes follow
//   one per cycle unless stalled. Each point yields eight node results; the
//   next point is taken while node 7 issues, so points stream with no gap.
//   Pipeline: point hold register, product stage, second product and
//   derivative rounding stage, shape rounding into the output register.
// Reset: asynchronous, active low; all stages empty, no point held.
// Stall: while node.valid is high and node.ready is low the whole pipeline
//   holds; nothing is dropped or repeated. point.ready stays low while a point
//   is held and rises in the cycle that point issues node 7.
module hex8_shape_function_eval
    import hex8sfe_pkg::*;
#(
    parameter int FRAC_BITS = 14
)
(
    input logic            clk,
    input logic            rst_n,
    hex8sfe_point_if.sink  point,
    hex8sfe_node_if.source node
);

    // Coordinate width for the clamp, factor width, product widths.
    localparam int XW = (FRAC_BITS + 3 > 17) ? FRAC_BITS + 3 : 17;
    localparam int FW = FRAC_BITS + 2;
    localparam int PW = 2 * FW;
    localparam int HW = PW - FRAC_BITS;
    localparam int LW = FRAC_BITS + FW;
    localparam int TW = HW + FW;

    localparam logic signed [XW-1:0] ONE_S = {{(XW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [PW:0] DRND = {{PW{1'b0}}, 1'b1} << (FRAC_BITS + 2);
    localparam logic [TW-1:0] SRND = {{(TW-1){1'b0}}, 1'b1} << (FRAC_BITS + 2);

    // Sign-extend a coordinate and clamp it to [-ONE, ONE].
    function automatic logic signed [XW-1:0] clamp_coord(input logic [15:0] raw);
        logic signed [XW-1:0] v;
        v = {{(XW-16){raw[15]}}, raw};
        if (v > ONE_S)
        begin
            v = ONE_S;
        end
        if (v < -ONE_S)
        begin
            v = -ONE_S;
        end
        return v;
    endfunction

    // Round a two-factor product to a derivative, saturate, apply the corner sign.
    function automatic logic [14:0] round_deriv(input logic [PW-1:0] p, input logic pos);
        logic [PW:0]  sum;
        logic [PW:0]  mag;
        logic [13:0]  mag14;
        sum = {1'b0, p} + DRND;
        mag = sum >> (FRAC_BITS + 3);
        if (mag > (PW+1)'(DERIV_MAG_MAX))
        begin
            mag14 = DERIV_MAG_MAX;
        end
        else
        begin
            mag14 = mag[13:0];
        end
        return pos ? {1'b0, mag14} : (15'd0 - {1'b0, mag14});
    endfunction

    // Pipeline advance: the output register is free or being taken.
    logic adv;
    assign adv = !node.valid || node.ready;

    // ---------------------------------------------------------------
    // Point hold register and node sequencer
    // ---------------------------------------------------------------
    logic          hold_valid_reg;
    logic [2:0]    node_cnt_reg;
    logic [FW-1:0] fxp_reg, fxn_reg, fyp_reg, fyn_reg, fzp_reg, fzn_reg;
    logic          accept;
    logic          issue;
    logic signed [XW-1:0] cx, cy, cz;
    logic signed [XW-1:0] sxp, sxn, syp, syn, szp, szn;

    assign issue = hold_valid_reg && adv;
    assign point.ready = !hold_valid_reg || (adv && node_cnt_reg == LAST_NODE);
    assign accept = point.valid && point.ready;

    // Form the six factors ONE +/- c of the incoming point.
    always_comb
    begin
        cx  = clamp_coord(point.coord_xi);
        cy  = clamp_coord(point.coord_eta);
        cz  = clamp_coord(point.coord_zeta);
        sxp = ONE_S + cx;
        sxn = ONE_S - cx;
        syp = ONE_S + cy;
        syn = ONE_S - cy;
        szp = ONE_S + cz;
        szn = ONE_S - cz;
    end

    // Load a new point or advance through its nodes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            node_cnt_reg   <= 3'd0;
        end
        else if (accept)
        begin
            hold_valid_reg <= 1'b1;
            node_cnt_reg   <= 3'd0;
        end
        else if (issue)
        begin
            if (node_cnt_reg == LAST_NODE)
            begin
                hold_valid_reg <= 1'b0;
            end
            node_cnt_reg <= node_cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fxp_reg <= sxp[FW-1:0];
            fxn_reg <= sxn[FW-1:0];
            fyp_reg <= syp[FW-1:0];
            fyn_reg <= syn[FW-1:0];
            fzp_reg <= szp[FW-1:0];
            fzn_reg <= szn[FW-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: select node factors, form the pairwise products
    // ---------------------------------------------------------------
    logic          s1_valid_reg;
    logic [2:0]    s1_node_reg;
    logic [2:0]    s1_bits_reg;
    logic [PW-1:0] s1_xy_reg, s1_yz_reg, s1_xz_reg;
    logic [FW-1:0] s1_fz_reg;
    logic [2:0]    s1_bits_next;
    logic [FW-1:0] fx, fy, fz;
    logic [PW-1:0] s1_xy_next, s1_yz_next, s1_xz_next;

    always_comb
    begin
        s1_bits_next = corner_bits(node_cnt_reg);
        fx = s1_bits_next[0] ? fxp_reg : fxn_reg;
        fy = s1_bits_next[1] ? fyp_reg : fyn_reg;
        fz = s1_bits_next[2] ? fzp_reg : fzn_reg;
        s1_xy_next = PW'(fx) * PW'(fy);
        s1_yz_next = PW'(fy) * PW'(fz);
        s1_xz_next = PW'(fx) * PW'(fz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_node_reg <= node_cnt_reg;
            s1_bits_reg <= s1_bits_next;
            s1_xy_reg   <= s1_xy_next;
            s1_yz_reg   <= s1_yz_next;
            s1_xz_reg   <= s1_xz_next;
            s1_fz_reg   <= fz;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: split products for the triple product, round derivatives
    // ---------------------------------------------------------------
    logic          s2_valid_reg;
    logic [2:0]    s2_node_reg;
    logic [TW-1:0] s2_hi_reg;
    logic [LW-1:0] s2_lo_reg;
    logic [14:0]   s2_dxi_reg, s2_deta_reg, s2_dzeta_reg;
    logic [TW-1:0] s2_hi_next;
    logic [LW-1:0] s2_lo_next;

    always_comb
    begin
        s2_hi_next = TW'(s1_xy_reg[PW-1:FRAC_BITS]) * TW'(s1_fz_reg);
        s2_lo_next = LW'(s1_xy_reg[FRAC_BITS-1:0]) * LW'(s1_fz_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_node_reg  <= s1_node_reg;
            s2_hi_reg    <= s2_hi_next;
            s2_lo_reg    <= s2_lo_next;
            s2_dxi_reg   <= round_deriv(s1_yz_reg, s1_bits_reg[0]);
            s2_deta_reg  <= round_deriv(s1_xz_reg, s1_bits_reg[1]);
            s2_dzeta_reg <= round_deriv(s1_xy_reg, s1_bits_reg[2]);
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: sum, round and saturate the shape value into the output
    // ---------------------------------------------------------------
    logic          out_valid_reg;
    logic [2:0]    out_node_reg;
    logic [14:0]   out_shape_reg;
    logic [14:0]   out_dxi_reg, out_deta_reg, out_dzeta_reg;
    logic [TW-1:0] t_sum;
    logic [TW-1:0] shp;
    logic [14:0]   out_shape_next;

    always_comb
    begin
        t_sum = s2_hi_reg + TW'(s2_lo_reg >> FRAC_BITS) + SRND;
        shp   = t_sum >> (FRAC_BITS + 3);
        if (shp > TW'(SHAPE_MAX))
        begin
            out_shape_next = SHAPE_MAX;
        end
        else
        begin
            out_shape_next = shp[14:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_node_reg  <= s2_node_reg;
            out_shape_reg <= out_shape_next;
            out_dxi_reg   <= s2_dxi_reg;
            out_deta_reg  <= s2_deta_reg;
            out_dzeta_reg <= s2_dzeta_reg;
        end
    end

    // Drive the result channel from the output register.
    assign node.valid       = out_valid_reg;
    assign node.node_index  = out_node_reg;
    assign node.shape_value = out_shape_reg;
    assign node.deriv_xi    = out_dxi_reg;
    assign node.deriv_eta   = out_deta_reg;
    assign node.deriv_zeta  = out_dzeta_reg;
    assign node.last_node   = (out_node_reg == LAST_NODE);

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
`include "hex8_shape_function_eval_macros.svh"

    `HEX8SFE_ASSERT_NEXT(a_accept_starts_node0, accept,
        hold_valid_reg && node_cnt_reg == 3'd0, "accepted point does not start at node 0")
    `HEX8SFE_ASSERT_NEXT(a_node_steps, issue && !accept && node_cnt_reg != LAST_NODE,
        hold_valid_reg && node_cnt_reg == $past(node_cnt_reg) + 3'd1,
        "node sequencer skipped or repeated a node")
    `HEX8SFE_ASSERT_SAME(a_no_accept_mid_point, hold_valid_reg && node_cnt_reg != LAST_NODE,
        !point.ready, "point accepted before the held point finished")

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the hex8 shape function evaluator: directed and random points in, node items checked.
module testbench
    import hex8sfe_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS = 14;
    localparam longint FX_ONE = 64'sd1 << FRAC_BITS;
    localparam longint unsigned SHAPE_HALF = 64'd1 << (2 * FRAC_BITS + 2);
    localparam longint unsigned DERIV_HALF = 64'd1 << (FRAC_BITS + 2);
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AT_POINT = 60;
    localparam int RANDOM_PER_PHASE = 160;

    // Corner signs per node, node 0 in the low bits: bit0 xi, bit1 eta, bit2 zeta positive
    localparam logic [7:0][2:0] CORNER_SIGNS = {3'b110, 3'b111, 3'b101, 3'b100,
                                                3'b010, 3'b011, 3'b001, 3'b000};

    typedef struct packed {
        logic signed [15:0] xi;
        logic signed [15:0] eta;
        logic signed [15:0] zeta;
    } point_t;

    typedef struct packed {
        logic        [2:0]  node_index;
        logic        [14:0] shape_value;
        logic signed [14:0] deriv_xi;
        logic signed [14:0] deriv_eta;
        logic signed [14:0] deriv_zeta;
        logic               last_node;
    } node_result_t;

    logic clk = 1'b0;
    logic rst_n;

    hex8sfe_point_if point_ch ();
    hex8sfe_node_if  node_ch ();

    hex8_shape_function_eval #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .point (point_ch.sink),
        .node  (node_ch.source)
    );

    point_t       pending_points [$];
    node_result_t expected_nodes [$];
    point_t       next_point;
    int           sender_idle_pct;
    int           receiver_idle_pct;
    int           points_accepted;
    int           nodes_checked = 0;
    int           mismatch_count = 0;
    int           hold_cycles;
    logic         hold_done;
    int           hold_stall_cycles;

    // Free-running clock, 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Clamp a raw coordinate to [-1, 1]
    function automatic longint clamp_coord(input logic signed [15:0] raw);
        longint v;
        v = raw;
        if (v > FX_ONE)
        begin
            v = FX_ONE;
        end
        if (v < -FX_ONE)
        begin
            v = -FX_ONE;
        end
        return v;
    endfunction

    // Saturate a derivative magnitude and apply the corner sign
    function automatic logic signed [14:0] apply_corner_sign(input longint unsigned mag,
                                                             input logic pos);
        logic [14:0] m;
        if (mag > DERIV_MAG_MAX)
        begin
            mag = DERIV_MAG_MAX;
        end
        m = mag[14:0];
        return pos ? m : -m;
    endfunction

    // Compute the eight node items of one point and queue them
    function automatic void predict_point_nodes(input point_t pt);
        longint          x;
        longint          y;
        longint          z;
        longint unsigned fx;
        longint unsigned fy;
        longint unsigned fz;
        longint unsigned shape;
        logic [2:0]      s;
        node_result_t    r;
        int              k;
        x = clamp_coord(pt.xi);
        y = clamp_coord(pt.eta);
        z = clamp_coord(pt.zeta);
        for (k = 0; k < NODE_COUNT; k++)
        begin
            s = CORNER_SIGNS[k];
            fx = s[0] ? FX_ONE + x : FX_ONE - x;
            fy = s[1] ? FX_ONE + y : FX_ONE - y;
            fz = s[2] ? FX_ONE + z : FX_ONE - z;
            shape = (fx * fy * fz + SHAPE_HALF) >> (2 * FRAC_BITS + 3);
            if (shape > SHAPE_MAX)
            begin
                shape = SHAPE_MAX;
            end
            r.node_index = k[2:0];
            r.shape_value = shape[14:0];
            r.deriv_xi = apply_corner_sign((fy * fz + DERIV_HALF) >> (FRAC_BITS + 3), s[0]);
            r.deriv_eta = apply_corner_sign((fx * fz + DERIV_HALF) >> (FRAC_BITS + 3), s[1]);
            r.deriv_zeta = apply_corner_sign((fx * fy + DERIV_HALF) >> (FRAC_BITS + 3), s[2]);
            r.last_node = (k[2:0] == LAST_NODE);
            expected_nodes.push_back(r);
        end
    endfunction

    // Pick one coordinate: mostly in range, some raw 16-bit, some at or just inside the corners, some past them
    function automatic logic [15:0] random_coord();
        int v;
        case ($urandom_range(9))
            6, 7: v = int'($urandom_range(65535)) - 32768;
            8: v = (16384 - int'($urandom_range(3))) * ($urandom_range(1) ? 1 : -1);
            9: v = $urandom_range(1) ? int'($urandom_range(32767, 16385))
                                     : -int'($urandom_range(32768, 16385));
            default: v = int'($urandom_range(32768)) - 16384;
        endcase
        return v[15:0];
    endfunction

    function automatic point_t random_point();
        point_t p;
        p.xi = random_coord();
        p.eta = random_coord();
        p.zeta = random_coord();
        return p;
    endfunction

    task automatic queue_point(input int x, input int y, input int z);
        point_t p;
        p.xi = x[15:0];
        p.eta = y[15:0];
        p.zeta = z[15:0];
        pending_points.push_back(p);
    endtask

    task automatic compare_field(input int node, input string name,
                                 input logic signed [31:0] exp_v,
                                 input logic signed [31:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatch_count++;
            $display("%0t: node %0d %s mismatch: expected %0d, actual %0d",
                     $time, node, name, exp_v, act_v);
        end
    endtask

    task automatic check_node(input node_result_t exp_r);
        int n;
        n = exp_r.node_index;
        nodes_checked++;
        compare_field(n, "node_index", exp_r.node_index, node_ch.node_index);
        compare_field(n, "shape_value", exp_r.shape_value, node_ch.shape_value);
        compare_field(n, "deriv_xi", exp_r.deriv_xi, node_ch.deriv_xi);
        compare_field(n, "deriv_eta", exp_r.deriv_eta, node_ch.deriv_eta);
        compare_field(n, "deriv_zeta", exp_r.deriv_zeta, node_ch.deriv_zeta);
        compare_field(n, "last_node", exp_r.last_node, node_ch.last_node);
    endtask

    // Point driver: offer the next queued item once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_ch.valid <= 1'b0;
            point_ch.coord_xi <= '0;
            point_ch.coord_eta <= '0;
            point_ch.coord_zeta <= '0;
            points_accepted <= 0;
        end
        else
        begin
            if (point_ch.valid && point_ch.ready)
            begin
                predict_point_nodes({point_ch.coord_xi, point_ch.coord_eta,
                                     point_ch.coord_zeta});
                points_accepted <= points_accepted + 1;
            end
            if (!point_ch.valid || point_ch.ready)
            begin
                if (pending_points.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_point = pending_points.pop_front();
                    point_ch.valid <= 1'b1;
                    point_ch.coord_xi <= next_point.xi;
                    point_ch.coord_eta <= next_point.eta;
                    point_ch.coord_zeta <= next_point.zeta;
                end
                else
                begin
                    point_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off once, while the sender keeps offering points
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cycles <= 0;
            hold_done <= 1'b0;
            hold_stall_cycles <= 0;
        end
        else
        begin
            if (!hold_done && points_accepted == HOLD_OFF_AT_POINT)
            begin
                hold_cycles <= HOLD_OFF_CYCLES;
                hold_done <= 1'b1;
            end
            else if (hold_cycles != 0)
            begin
                hold_cycles <= hold_cycles - 1;
            end
            if (hold_cycles != 0 && point_ch.valid && !point_ch.ready)
            begin
                hold_stall_cycles <= hold_stall_cycles + 1;
            end
        end
    end

    // Node monitor: check each taken item against the oldest expected one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_ch.ready <= 1'b0;
        end
        else
        begin
            if (node_ch.valid && node_ch.ready)
            begin
                if (expected_nodes.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected node item: expected none, actual node %0d shape %0d",
                             $time, node_ch.node_index, node_ch.shape_value);
                end
                else
                begin
                    check_node(expected_nodes.pop_front());
                end
            end
            node_ch.ready <= (hold_cycles == 0) && ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    task automatic wait_points_taken();
        while (pending_points.size() != 0 || point_ch.valid)
        begin
            @(posedge clk);
        end
    endtask

    // Stimulus: directed center, corner, clamped and tie points, then three idle patterns of random points
    initial
    begin
        rst_n = 1'b0;
        sender_idle_pct = 7;
        receiver_idle_pct = 55;
        repeat (8) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // center, all eight corners of the cube
        queue_point(0, 0, 0);
        queue_point(-16384, -16384, -16384);
        queue_point(16384, -16384, -16384);
        queue_point(16384, 16384, -16384);
        queue_point(-16384, 16384, -16384);
        queue_point(-16384, -16384, 16384);
        queue_point(16384, -16384, 16384);
        queue_point(16384, 16384, 16384);
        queue_point(-16384, 16384, 16384);
        // out of range: clamped to the faces
        queue_point(-32768, 32767, 16385);
        queue_point(-16385, -32768, 32767);
        queue_point(32767, 32767, 32767);
        queue_point(-32768, -32768, -32768);
        queue_point(16385, -16385, 0);
        // smallest steps off the center and the faces
        queue_point(1, -1, 0);
        queue_point(16383, -16383, 1);
        // derivative rounding tie (product of factors exactly half an LSB)
        queue_point(0, -16128, -16128);
        queue_point(16128, 16128, 0);
        // shape rounding tie
        queue_point(-15360, -15360, -15360);
        queue_point(15360, 15360, 15360);
        // mid points and mixed signs
        queue_point(8192, -8192, 4096);
        queue_point(-4096, 12288, -12288);
        queue_point(21845, -21846, 5461);

        repeat (RANDOM_PER_PHASE) pending_points.push_back(random_point());
        wait_points_taken();

        sender_idle_pct = 55;
        receiver_idle_pct = 7;
        repeat (RANDOM_PER_PHASE) pending_points.push_back(random_point());
        wait_points_taken();

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        repeat (RANDOM_PER_PHASE) pending_points.push_back(random_point());
        wait_points_taken();

        while (expected_nodes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);

        $display("Checked %0d points as %0d node items: corners, clamped and tie coordinates,",
                 points_accepted, nodes_checked);
        $display("three idle patterns, input stalled %0d cycles during the receiver hold-off.",
                 hold_stall_cycles);
        if (mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #3ms;
        $display("Timeout with %0d node items still expected", expected_nodes.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: hex8_shape_function_eval.f
+incdir+src
src/hex8sfe_pkg.sv
src/hex8sfe_if.sv
src/hex8_shape_function_eval.sv
dv/testbench.sv
